/* hw/rtl/vgmcsp_pkg.sv */
package vgmcsp_pkg;

    localparam int PCM_BANK_DEPTH = 65536;
    localparam int BANK_AW = $clog2(PCM_BANK_DEPTH);
    localparam int LEN_W = BANK_AW + 1;

    localparam logic [7:0] OP_PSG = 8'h50;
    localparam logic [7:0] OP_STEREO = 8'h4F;
    localparam logic [7:0] OP_FM0 = 8'h52;
    localparam logic [7:0] OP_FM1 = 8'h53;
    localparam logic [7:0] OP_WAIT = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL = 8'h63;
    localparam logic [7:0] OP_END = 8'h66;
    localparam logic [7:0] OP_BLOCK = 8'h67;
    localparam logic [7:0] OP_SEEK = 8'hE0;
    localparam logic [7:0] BLOCK_MARKER = 8'h66;
    localparam logic [7:0] DAC_REG = 8'h2A;
    localparam logic [15:0] WAIT_NTSC = 16'd735;
    localparam logic [15:0] WAIT_PAL = 16'd882;

    typedef enum logic [3:0] {
        EV_PSG = 4'd0,
        EV_FM = 4'd1,
        EV_WAIT = 4'd2,
        EV_DAC = 4'd3,
        EV_BLOCK = 4'd4,
        EV_SEEK = 4'd5,
        EV_STEREO = 4'd6,
        EV_SKIP = 4'd7,
        EV_END = 4'd8,
        EV_ERROR = 4'd9
    } t_ev_kind;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_ARGS,
        PH_MARKER,
        PH_BTYPE,
        PH_BSIZE,
        PH_BDATA
    } t_phase;

    typedef enum logic [1:0] {
        HALT_RUN,
        HALT_END,
        HALT_ERR
    } t_halt;

    typedef struct packed {
        t_ev_kind    kind;
        logic        chip_port;
        logic [7:0]  reg_addr;
        logic [7:0]  write_data;
        logic [15:0] wait_count;
        logic        dac_underrun;
        logic [31:0] seek_offset;
        logic [7:0]  block_type;
        logic [31:0] block_size;
        logic [7:0]  command_code;
        logic [31:0] command_offset;
        logic        use_bank;
    } t_evt;

    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [BANK_AW-1:0] raddr;
    } t_bank_req;

    function automatic logic [3:0] arg_total(input logic [7:0] op);
        case (op)
            8'h50, 8'h4F, 8'h30, 8'h94: arg_total = 4'd1;
            8'h52, 8'h53, 8'h61, 8'h51, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
            8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5E, 8'h5F, 8'hA0: arg_total = 4'd2;
            8'hE0, 8'h90, 8'h91, 8'h95: arg_total = 4'd4;
            8'h92: arg_total = 4'd5;
            8'h93: arg_total = 4'd10;
            8'h68: arg_total = 4'd11;
            default: arg_total = 4'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/vgmcsp_ram.sv */
module vgmcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/vgmcsp_parser.sv */
module vgmcsp_parser
    import vgmcsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  logic [7:0] i_byte,
    output logic      o_evt_valid,
    output t_evt      o_evt,
    output t_bank_req o_bank
);

    localparam logic [31:0] DEPTH32 = 32'(PCM_BANK_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(PCM_BANK_DEPTH);

    t_phase            r_phase, n_phase;
    t_halt             r_halt, n_halt;
    logic [7:0]        r_held_op, n_held_op;
    logic [3:0]        r_args_left, n_args_left;
    logic [3:0]        r_arg_idx, n_arg_idx;
    logic [31:0]       r_arg_shift, n_arg_shift;
    logic [31:0]       r_block_left, n_block_left;
    logic [LEN_W-1:0]  r_blk_idx, n_blk_idx;
    logic [7:0]        r_block_type, n_block_type;
    logic [LEN_W-1:0]  r_pcm_len, n_pcm_len;
    logic [31:0]       r_pcm_ptr, n_pcm_ptr;
    logic [31:0]       r_byte_pos, n_byte_pos;
    logic [31:0]       r_cmd_start, n_cmd_start;

    logic [31:0] placed;
    logic [3:0]  tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPCODE;
            r_halt       <= HALT_RUN;
            r_held_op    <= '0;
            r_args_left  <= '0;
            r_arg_idx    <= '0;
            r_arg_shift  <= '0;
            r_block_left <= '0;
            r_blk_idx    <= '0;
            r_block_type <= '0;
            r_pcm_len    <= '0;
            r_pcm_ptr    <= '0;
            r_byte_pos   <= '0;
            r_cmd_start  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_halt       <= n_halt;
            r_held_op    <= n_held_op;
            r_args_left  <= n_args_left;
            r_arg_idx    <= n_arg_idx;
            r_arg_shift  <= n_arg_shift;
            r_block_left <= n_block_left;
            r_blk_idx    <= n_blk_idx;
            r_block_type <= n_block_type;
            r_pcm_len    <= n_pcm_len;
            r_pcm_ptr    <= n_pcm_ptr;
            r_byte_pos   <= n_byte_pos;
            r_cmd_start  <= n_cmd_start;
        end
    end

    always_comb begin
        case (r_arg_idx)
            4'd0: placed = {24'd0, i_byte};
            4'd1: placed = {16'd0, i_byte, 8'd0};
            4'd2: placed = {8'd0, i_byte, 16'd0};
            4'd3: placed = {i_byte, 24'd0};
            default: placed = '0;
        endcase
    end

    assign tot = arg_total(i_byte);

    always_comb begin
        n_phase      = r_phase;
        n_halt       = r_halt;
        n_held_op    = r_held_op;
        n_args_left  = r_args_left;
        n_arg_idx    = r_arg_idx;
        n_arg_shift  = r_arg_shift;
        n_block_left = r_block_left;
        n_blk_idx    = r_blk_idx;
        n_block_type = r_block_type;
        n_pcm_len    = r_pcm_len;
        n_pcm_ptr    = r_pcm_ptr;
        n_byte_pos   = r_byte_pos;
        n_cmd_start  = r_cmd_start;
        o_evt_valid  = 1'b0;
        o_evt        = '0;
        o_evt.command_code   = r_held_op;
        o_evt.command_offset = r_cmd_start;
        o_bank       = '0;
        o_bank.waddr = r_blk_idx[BANK_AW-1:0];
        o_bank.wdata = i_byte;
        o_bank.raddr = r_pcm_ptr[BANK_AW-1:0];

        if (i_take && r_halt == HALT_RUN) begin
            n_byte_pos = r_byte_pos + 32'd1;
            case (r_phase)
                PH_OPCODE: begin
                    n_cmd_start = r_byte_pos;
                    n_held_op   = i_byte;
                    n_arg_shift = '0;
                    n_arg_idx   = '0;
                    o_evt.command_code   = i_byte;
                    o_evt.command_offset = r_byte_pos;
                    if (i_byte == OP_BLOCK) begin
                        n_phase = PH_MARKER;
                    end else if (tot != 4'd0) begin
                        n_args_left = tot;
                        n_phase     = PH_ARGS;
                    end else if (i_byte == OP_WAIT_NTSC || i_byte == OP_WAIT_PAL) begin
                        o_evt_valid      = 1'b1;
                        o_evt.kind       = EV_WAIT;
                        o_evt.wait_count = (i_byte == OP_WAIT_NTSC) ? WAIT_NTSC : WAIT_PAL;
                    end else if (i_byte == OP_END) begin
                        o_evt_valid = 1'b1;
                        o_evt.kind  = EV_END;
                        n_halt      = HALT_END;
                    end else if (i_byte[7:4] == 4'h7) begin
                        o_evt_valid      = 1'b1;
                        o_evt.kind       = EV_WAIT;
                        o_evt.wait_count = 16'(i_byte[3:0]) + 16'd1;
                    end else if (i_byte[7:4] == 4'h8) begin
                        o_evt_valid      = 1'b1;
                        o_evt.kind       = EV_DAC;
                        o_evt.reg_addr   = DAC_REG;
                        o_evt.wait_count = 16'(i_byte[3:0]);
                        if (r_pcm_ptr < 32'(r_pcm_len)) begin
                            o_evt.use_bank = 1'b1;
                            o_bank.re      = 1'b1;
                            n_pcm_ptr      = r_pcm_ptr + 32'd1;
                        end else begin
                            o_evt.dac_underrun = 1'b1;
                        end
                    end else begin
                        o_evt_valid = 1'b1;
                        o_evt.kind  = EV_ERROR;
                        n_halt      = HALT_ERR;
                    end
                end
                PH_ARGS: begin
                    if (r_arg_idx < 4'd4) begin
                        n_arg_shift = r_arg_shift | placed;
                    end
                    n_arg_idx   = r_arg_idx + 4'd1;
                    n_args_left = r_args_left - 4'd1;
                    if (r_args_left == 4'd1) begin
                        n_phase     = PH_OPCODE;
                        o_evt_valid = 1'b1;
                        if (r_held_op == OP_PSG) begin
                            o_evt.kind       = EV_PSG;
                            o_evt.write_data = n_arg_shift[7:0];
                        end else if (r_held_op == OP_FM0 || r_held_op == OP_FM1) begin
                            o_evt.kind       = EV_FM;
                            o_evt.chip_port  = (r_held_op == OP_FM1);
                            o_evt.reg_addr   = n_arg_shift[7:0];
                            o_evt.write_data = n_arg_shift[15:8];
                        end else if (r_held_op == OP_WAIT) begin
                            o_evt.kind       = EV_WAIT;
                            o_evt.wait_count = n_arg_shift[15:0];
                        end else if (r_held_op == OP_SEEK) begin
                            o_evt.kind        = EV_SEEK;
                            o_evt.seek_offset = n_arg_shift;
                            n_pcm_ptr         = n_arg_shift;
                        end else if (r_held_op == OP_STEREO) begin
                            o_evt.kind = EV_STEREO;
                        end else begin
                            o_evt.kind = EV_SKIP;
                        end
                    end
                end
                PH_MARKER: begin
                    if (i_byte != BLOCK_MARKER) begin
                        n_halt      = HALT_ERR;
                        n_phase     = PH_OPCODE;
                        o_evt_valid = 1'b1;
                        o_evt.kind  = EV_ERROR;
                    end else begin
                        n_phase = PH_BTYPE;
                    end
                end
                PH_BTYPE: begin
                    n_block_type = i_byte;
                    n_arg_shift  = '0;
                    n_arg_idx    = '0;
                    n_args_left  = 4'd4;
                    n_phase      = PH_BSIZE;
                end
                PH_BSIZE: begin
                    n_arg_shift = r_arg_shift | placed;
                    n_arg_idx   = r_arg_idx + 4'd1;
                    n_args_left = r_args_left - 4'd1;
                    if (r_args_left == 4'd1) begin
                        if (r_block_type == 8'd0) begin
                            n_pcm_len = (n_arg_shift >= DEPTH32) ? DEPTH_L
                                                                 : n_arg_shift[LEN_W-1:0];
                            n_pcm_ptr = '0;
                        end
                        n_block_left = n_arg_shift;
                        n_blk_idx    = '0;
                        if (n_arg_shift == 32'd0) begin
                            n_phase          = PH_OPCODE;
                            o_evt_valid      = 1'b1;
                            o_evt.kind       = EV_BLOCK;
                            o_evt.block_type = r_block_type;
                            o_evt.block_size = n_arg_shift;
                        end else begin
                            n_phase = PH_BDATA;
                        end
                    end
                end
                PH_BDATA: begin
                    if (r_blk_idx < DEPTH_L) begin
                        o_bank.we = (r_block_type == 8'd0);
                        n_blk_idx = r_blk_idx + LEN_W'(1);
                    end
                    n_block_left = r_block_left - 32'd1;
                    if (r_block_left == 32'd1) begin
                        n_phase          = PH_OPCODE;
                        o_evt_valid      = 1'b1;
                        o_evt.kind       = EV_BLOCK;
                        o_evt.block_type = r_block_type;
                        o_evt.block_size = r_arg_shift;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt != HALT_RUN) |-> (!o_evt_valid && !o_bank.we && !o_bank.re))
        else $error("event or bank access while halted");

    a_bank_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_bank.we && o_bank.re))
        else $error("bank written and read in one cycle");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcm_len <= DEPTH_L)
        else $error("pcm length beyond bank depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bank.re |-> (r_pcm_ptr < 32'(r_pcm_len) && o_evt_valid && !o_evt.dac_underrun))
        else $error("bank read outside filled range");

endmodule

/* hw/rtl/vgm_command_stream_player_core.sv */
// Command stream player.
// Input channel: i_valid / o_stall with one command byte on i_stream_byte per
// request, starting at the first command of the stream. Output channel: o_valid /
// i_stall with one decoded event per complete command on the o_* fields; argument
// and block data bytes produce no event.
// Throughput: one byte per cycle while o_stall is low. The event of the byte that
// completes its command goes to the staging register, alongside the registered read
// of the PCM bank used by 0x8n DAC write commands, and then to the output register.
// The result passes through a staging register and an output register, so a byte
// is still accepted while an event waits; o_stall rises only when both are full and
// the receiver stalls. A stalled event holds its fields.
// Reset (synchronous, active low) returns the parser to opcode phase, clears PCM
// length, pointer and byte position, and empties both registers. The PCM bank is
// not cleared; only entries written by a type-0 data block are ever read.
// After an end or error event further bytes are accepted and dropped until reset.
module vgm_command_stream_player_core
    import vgmcsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_kind,
    output logic        o_chip_port,
    output logic [7:0]  o_reg_addr,
    output logic [7:0]  o_write_data,
    output logic [15:0] o_wait_count,
    output logic        o_dac_underrun,
    output logic [31:0] o_seek_offset,
    output logic [7:0]  o_block_type,
    output logic [31:0] o_block_size,
    output logic [7:0]  o_command_code,
    output logic [31:0] o_command_offset
);

    logic      take;
    logic      evt_valid;
    t_evt      evt;
    t_bank_req bank;
    logic [7:0] bank_rdata;
    logic      move;

    logic r_s1_valid, n_s1_valid;
    t_evt r_s1;
    logic r_out_valid, n_out_valid;
    t_evt r_out, n_out;

    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign move    = r_s1_valid && (!r_out_valid || !i_stall);

    vgmcsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_stream_byte),
        .o_evt_valid (evt_valid),
        .o_evt       (evt),
        .o_bank      (bank)
    );

    vgmcsp_ram #(
        .WIDTH (8),
        .DEPTH (PCM_BANK_DEPTH)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (bank.we),
        .i_waddr (bank.waddr),
        .i_wdata (bank.wdata),
        .i_re    (bank.re),
        .i_raddr (bank.raddr),
        .o_rdata (bank_rdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (take) begin
            n_s1_valid = evt_valid;
        end else if (move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (move) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
        n_out = r_out;
        if (move) begin
            n_out = r_s1;
            if (r_s1.use_bank) begin
                n_out.write_data = bank_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= evt;
        end
        r_out <= n_out;
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_out.kind;
    assign o_chip_port      = r_out.chip_port;
    assign o_reg_addr       = r_out.reg_addr;
    assign o_write_data     = r_out.write_data;
    assign o_wait_count     = r_out.wait_count;
    assign o_dac_underrun   = r_out.dac_underrun;
    assign o_seek_offset    = r_out.seek_offset;
    assign o_block_type     = r_out.block_type;
    assign o_block_size     = r_out.block_size;
    assign o_command_code   = r_out.command_code;
    assign o_command_offset = r_out.command_offset;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_s1_valid) |-> move)
        else $error("staged event overwritten");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_kind <= EV_ERROR))
        else $error("event kind out of range");

endmodule
